/* hdl/sbqt_pkg.sv */
// Package: status codes, request modes and shared types for the semaphore queue table.
`default_nettype none
package sbqt_pkg;

  typedef enum logic [1:0] {
    MODE_BLOCK   = 2'd0,
    MODE_UNBLOCK = 2'd1,
    MODE_REMOVE  = 2'd2,
    MODE_QUERY   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFREE   = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  localparam int KEY_W  = 32;
  localparam int PROC_W = 5;

endpackage
`default_nettype wire

/* hdl/sbqt_keymatch.sv */
// Key match and free-descriptor search over the descriptor key table.
`default_nettype none
module sbqt_keymatch #(
  parameter int NUM_PROCS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(NUM_PROCS)-1:0]  wr_idx,
  input  wire logic [31:0]                   wr_key,
  input  wire logic [NUM_PROCS-1:0]          valid,
  input  wire logic [31:0]                   key,
  output logic                               hit,
  output logic [$clog2(NUM_PROCS)-1:0]       hit_idx,
  output logic                               free_ok,
  output logic [$clog2(NUM_PROCS)-1:0]       free_idx
);
  localparam int DW = $clog2(NUM_PROCS);

  // keys sit in flops: every entry is compared at once
  logic [31:0] key_r [NUM_PROCS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_r[wr_idx] <= wr_key;
    end
  end

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int d = NUM_PROCS - 1; d >= 0; d--) begin
      if (valid[d] && key_r[d] == key) begin
        hit     = 1'b1;
        hit_idx = DW'(d);
      end
      if (!valid[d]) begin
        free_ok  = 1'b1;
        free_idx = DW'(d);
      end
    end
  end
endmodule
`default_nettype wire

/* hdl/semaphore_blocked_queue_table.sv */
// Top level: semaphore descriptor table with per-semaphore FIFOs of blocked processes.
//
// One request per input word (mode, sem_key, proc_id), one result word per request
// (status, proc_valid, result_proc). Modes: block, unblock head, remove a given
// process, query head.
// The accept edge registers the word and reads the per-process links
// (next/prev/descriptor, registered read). The next edge does the key match, reads
// head/tail, writes back and loads the result, which is then offered.
// A new word is taken only once the result has left, so one word is finished before
// the next is accepted; the spacing is set by the read-modify-write of the link
// memories plus the state in which the result is handed over.
// Reset clears descriptor valid and process blocked bits; all link memories are then
// read only after being written. No clearing pass is needed.
// While out_stall is high the result word holds and in_stall stays high.
`default_nettype none
module semaphore_blocked_queue_table #(
  parameter int NUM_PROCS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_mode,
  input  wire logic [31:0]                in_sem_key,
  input  wire logic [4:0]                 in_proc_id,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      out_status,
  output logic                            out_proc_valid,
  output logic [4:0]                      out_result_proc
);
  import sbqt_pkg::*;

  localparam int DW = $clog2(NUM_PROCS);

  state_t state_r, state_nxt;

  logic [1:0]  mode_r;
  logic [31:0] key_r;
  logic [4:0]  pid_r;
  logic [DW-1:0] p_r;
  logic        prange_r;

  logic [NUM_PROCS-1:0] dvalid_r, dvalid_nxt;
  logic [NUM_PROCS-1:0] blocked_r, blocked_nxt;

  // link memories
  logic [DW-1:0] head_m [NUM_PROCS];
  logic [DW-1:0] tail_m [NUM_PROCS];
  logic [DW-1:0] next_m [NUM_PROCS];
  logic [DW-1:0] prev_m [NUM_PROCS];
  logic [DW-1:0] pdesc_m [NUM_PROCS];

  logic [DW-1:0] pnext_q, pprev_q, pdesc_q;

  logic          hit, free_ok;
  logic [DW-1:0] hit_idx, free_idx;

  logic [1:0] ost_r, ost_nxt;
  logic       opv_r, opv_nxt;
  logic [4:0] orp_r, orp_nxt;

  // descriptor choice for this request
  logic [DW-1:0] d;
  logic          d_ok;
  logic [DW-1:0] dhead_q, dtail_q;

  logic          key_we;
  logic          hd_we, tl_we, nx_we, pv_we, pd_we;
  logic [DW-1:0] hd_a, tl_a, nx_a, pv_a;
  logic [DW-1:0] hd_d, tl_d, nx_d, pv_d;

  sbqt_keymatch #(.NUM_PROCS(NUM_PROCS)) u_match (
    .clk      (clk),
    .wr_en    (key_we),
    .wr_idx   (free_idx),
    .wr_key   (key_r),
    .valid    (dvalid_r),
    .key      (key_r),
    .hit      (hit),
    .hit_idx  (hit_idx),
    .free_ok  (free_ok),
    .free_idx (free_idx)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_status      = ost_r;
  assign out_proc_valid  = opv_r;
  assign out_result_proc = orp_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // the key table sits in flops; head/tail are read combinationally by the matched
  // index (for remove, the stored descriptor); process links come from the registered memory read.
  always_comb begin
    if (mode_r == MODE_REMOVE) begin
      d    = pdesc_q;
      d_ok = prange_r && blocked_r[p_r] && dvalid_r[pdesc_q];
    end else begin
      d    = hit_idx;
      d_ok = hit;
    end
  end

  assign dhead_q = head_m[d];
  assign dtail_q = tail_m[d];

  always_comb begin
    dvalid_nxt  = dvalid_r;
    blocked_nxt = blocked_r;
    ost_nxt = ost_r;
    opv_nxt = opv_r;
    orp_nxt = orp_r;
    key_we = 1'b0;
    hd_we = 1'b0; tl_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0; pd_we = 1'b0;
    hd_a = d; tl_a = d; nx_a = dtail_q; pv_a = p_r;
    hd_d = p_r; tl_d = p_r; nx_d = p_r; pv_d = dtail_q;
    if (state_r == S_EXEC) begin
      ost_nxt = ST_OK;
      opv_nxt = 1'b0;
      orp_nxt = '0;
      case (mode_t'(mode_r))
        MODE_BLOCK: begin
          if (!prange_r) begin
            ost_nxt = ST_NOTFOUND;
          end else if (!blocked_r[p_r]) begin
            if (hit) begin
              nx_we = 1'b1;
              pv_we = 1'b1;
              tl_we = 1'b1;
              pd_we = 1'b1;
              blocked_nxt[p_r] = 1'b1;
            end else if (free_ok) begin
              key_we = 1'b1;
              hd_we = 1'b1; tl_we = 1'b1;
              hd_a = free_idx; tl_a = free_idx;
              dvalid_nxt[free_idx] = 1'b1;
              pd_we = 1'b1;
              blocked_nxt[p_r] = 1'b1;
            end else begin
              ost_nxt = ST_NOFREE;
            end
          end
        end
        MODE_UNBLOCK, MODE_QUERY: begin
          if (!d_ok) begin
            ost_nxt = ST_NOTFOUND;
          end else begin
            opv_nxt = 1'b1;
            orp_nxt = 5'(dhead_q);
            if (mode_r == MODE_UNBLOCK) begin
              blocked_nxt[dhead_q] = 1'b0;
              if (dhead_q == dtail_q) begin
                dvalid_nxt[d] = 1'b0;
              end else begin
                hd_we = 1'b1;
                hd_d  = next_m[dhead_q];
              end
            end
          end
        end
        default: begin
          if (!d_ok) begin
            ost_nxt = ST_NOTFOUND;
          end else begin
            opv_nxt = 1'b1;
            orp_nxt = pid_r;
            blocked_nxt[p_r] = 1'b0;
            if (dhead_q == p_r && dtail_q == p_r) begin
              dvalid_nxt[d] = 1'b0;
            end else if (dhead_q == p_r) begin
              hd_we = 1'b1; hd_d = pnext_q;
            end else if (dtail_q == p_r) begin
              tl_we = 1'b1; tl_d = pprev_q;
            end else begin
              nx_we = 1'b1; nx_a = pprev_q; nx_d = pnext_q;
              pv_we = 1'b1; pv_a = pnext_q; pv_d = pprev_q;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (hd_we) head_m[hd_a] <= hd_d;
    if (tl_we) tail_m[tl_a] <= tl_d;
    if (nx_we) next_m[nx_a] <= nx_d;
    if (pv_we) prev_m[pv_a] <= pv_d;
    if (pd_we) pdesc_m[p_r] <= (hit ? hit_idx : free_idx);
  end

  // registered read of the per-process links, addressed by the incoming word, and of the word itself
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      pnext_q <= next_m[in_proc_id[DW-1:0]];
      pprev_q <= prev_m[in_proc_id[DW-1:0]];
      pdesc_q <= pdesc_m[in_proc_id[DW-1:0]];
      mode_r   <= in_mode;
      key_r    <= in_sem_key;
      pid_r    <= in_proc_id;
      p_r      <= in_proc_id[DW-1:0];
      prange_r <= (32'(in_proc_id) < NUM_PROCS);
    end
    ost_r <= ost_nxt;
    opv_r <= opv_nxt;
    orp_r <= orp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      dvalid_r  <= '0;
      blocked_r <= '0;
    end else begin
      state_r   <= state_nxt;
      dvalid_r  <= dvalid_nxt;
      blocked_r <= blocked_nxt;
    end
  end
endmodule
`default_nettype wire

/* hdl/sbqt_checker.sv */
// Port-level checker for the semaphore queue table, bound to the top level.
`default_nettype none
module sbqt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_status,
  input wire logic       out_proc_valid,
  input wire logic [4:0] out_result_proc
);
  import sbqt_pkg::*;

  a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> ##1 out_valid)
    else $error("no result two cycles after accept");

  a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  a_proc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_proc_valid) |-> (out_result_proc == 5'd0))
    else $error("result_proc nonzero without proc_valid");

  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_proc_valid) |-> (out_status == ST_OK))
    else $error("proc_valid with error status");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)))
    else $error("stalled result changed");
endmodule

bind semaphore_blocked_queue_table sbqt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_proc_valid(out_proc_valid), .out_result_proc(out_result_proc)
);
`default_nettype wire

/* test/tb.sv */
// Testbench for the semaphore queue table: directed and random requests checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import sbqt_pkg::*;

  localparam int NPROC = 32;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = '0;
  logic [31:0] in_sem_key = '0;
  logic [4:0] in_proc_id = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic out_proc_valid;
  logic [4:0] out_result_proc;

  semaphore_blocked_queue_table #(.NUM_PROCS(NPROC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_sem_key(in_sem_key), .in_proc_id(in_proc_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_proc_valid(out_proc_valid),
    .out_result_proc(out_result_proc)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct packed {
    status_t    status;
    logic       pvalid;
    logic [4:0] rproc;
  } sem_result_t;

  // predictor state
  logic [31:0] tbl_key [NPROC];
  logic        tbl_used [NPROC];
  logic [4:0]  tbl_head [NPROC];
  logic [4:0]  tbl_tail [NPROC];
  logic [4:0]  lnk_next [NPROC];
  logic [4:0]  lnk_prev [NPROC];
  logic [4:0]  lnk_desc [NPROC];
  logic        is_waiting [NPROC];

  sem_result_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  logic [31:0] key_pool [8];

  function automatic int find_desc(logic [31:0] key);
    for (int d = 0; d < NPROC; d++)
      if (tbl_used[d] && tbl_key[d] == key) return d;
    return -1;
  endfunction

  function automatic void unlink(int d, logic [4:0] p);
    if (tbl_head[d] == p && tbl_tail[d] == p) tbl_used[d] = 1'b0;
    else if (tbl_head[d] == p) tbl_head[d] = lnk_next[p];
    else if (tbl_tail[d] == p) tbl_tail[d] = lnk_prev[p];
    else begin
      lnk_next[lnk_prev[p]] = lnk_next[p];
      lnk_prev[lnk_next[p]] = lnk_prev[p];
    end
    is_waiting[p] = 1'b0;
  endfunction

  function automatic sem_result_t apply_request(mode_t m, logic [31:0] key, logic [4:0] p);
    sem_result_t r;
    int d;
    r = '{ST_OK, 1'b0, 5'd0};
    case (m)
      MODE_BLOCK: begin
        if (!is_waiting[p]) begin
          d = find_desc(key);
          if (d >= 0) begin
            lnk_next[tbl_tail[d]] = p;
            lnk_prev[p] = tbl_tail[d];
            tbl_tail[d] = p;
          end else begin
            for (int i = 0; i < NPROC; i++)
              if (!tbl_used[i] && d < 0) d = i;
            if (d < 0) r.status = ST_NOFREE;
            else begin
              tbl_used[d] = 1'b1;
              tbl_key[d] = key;
              tbl_head[d] = p;
              tbl_tail[d] = p;
            end
          end
          if (d >= 0) begin
            lnk_desc[p] = d[4:0];
            is_waiting[p] = 1'b1;
          end
        end
      end
      MODE_UNBLOCK, MODE_QUERY: begin
        d = find_desc(key);
        if (d < 0) r.status = ST_NOTFOUND;
        else begin
          r.rproc = tbl_head[d];
          r.pvalid = 1'b1;
          if (m == MODE_UNBLOCK) unlink(d, r.rproc);
        end
      end
      default: begin
        if (!is_waiting[p] || !tbl_used[lnk_desc[p]]) r.status = ST_NOTFOUND;
        else begin
          unlink(lnk_desc[p], p);
          r.rproc = p;
          r.pvalid = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // valid stays up after an accept; it drops only when the sender idles
  task automatic send_request(mode_t m, logic [31:0] key, logic [4:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_sem_key <= key;
    in_proc_id <= p;
    pending_results.push_back(apply_request(m, key, p));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // receiver stall: random, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else
      out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    sem_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_proc_valid !== want.pvalid) begin
          $error("proc_valid: expected %0d, got %0d", want.pvalid, out_proc_valid);
          errors++;
        end
        if (out_result_proc !== want.rproc) begin
          $error("result_proc: expected %0d, got %0d", want.rproc, out_result_proc);
          errors++;
        end
      end
    end
  end

  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(MODE_QUERY, 32'd0, 5'd0);
    send_request(MODE_UNBLOCK, 32'hFFFF_FFFF, 5'd0);
    send_request(MODE_REMOVE, 32'd0, 5'd31);
    send_request(MODE_BLOCK, 32'd0, 5'd0);
    send_request(MODE_BLOCK, 32'hFFFF_FFFF, 5'd31);
    send_request(MODE_BLOCK, 32'd0, 5'd5);
    send_request(MODE_BLOCK, 32'd0, 5'd7);
    send_request(MODE_BLOCK, 32'd9, 5'd5);  // already waiting
    send_request(MODE_QUERY, 32'd0, 5'd0);
    send_request(MODE_REMOVE, 32'd0, 5'd5); // middle of queue
    send_request(MODE_REMOVE, 32'd0, 5'd7); // tail
    send_request(MODE_UNBLOCK, 32'd0, 5'd0);
    send_request(MODE_UNBLOCK, 32'd0, 5'd0); // freed
    send_request(MODE_REMOVE, 32'd0, 5'd31);
    send_request(MODE_QUERY, 32'hFFFF_FFFF, 5'd0);
  endtask

  // 32 distinct keys fill the table; a new key for an already waiting process is ignored
  task automatic test_table_full();
    for (int i = 0; i < NPROC; i++) send_request(MODE_BLOCK, 32'h1000 + i, i[4:0]);
    for (int i = 0; i < 2; i++) send_request(MODE_BLOCK, 32'h2000, 5'd0);
    for (int i = 0; i < NPROC; i++) send_request(MODE_REMOVE, 32'h5555_AAAA, i[4:0]);
  endtask

  task automatic test_random(int count);
    mode_t m;
    logic [31:0] key;
    for (int i = 0; i < count; i++) begin
      m = mode_t'($urandom_range(3));
      if ($urandom_range(9) == 0) key = $urandom();
      else key = key_pool[$urandom_range(7)];
      // bias toward blocking so queues grow
      if ($urandom_range(9) < 3) m = MODE_BLOCK;
      send_request(m, key, 5'($urandom_range(31)));
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    test_random(40);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    key_pool = '{32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678};
    for (int i = 0; i < NPROC; i++) begin
      tbl_used[i] = 1'b0;
      is_waiting[i] = 1'b0;
      tbl_key[i] = '0; tbl_head[i] = '0; tbl_tail[i] = '0;
      lnk_next[i] = '0; lnk_prev[i] = '0; lnk_desc[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    send_idle_pct = 14; recv_idle_pct = 62;
    test_random(600);
    send_idle_pct = 62; recv_idle_pct = 14;
    test_random(600);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random(500);
    drain();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire

/* semaphore_blocked_queue_table.f */
hdl/sbqt_pkg.sv
hdl/sbqt_keymatch.sv
hdl/semaphore_blocked_queue_table.sv
hdl/sbqt_checker.sv
test/tb.sv
